// ===== hw/rtl/udbtr_pkg.sv =====
// Package for the double-buffered UART core: operation codes, register
// indexes, width constants and the FIFO command bundle.
// No dependencies.
`timescale 1ns / 1ps

package udbtr_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_STATUS = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_RX     = 3'd3;
    localparam logic [2:0] OP_CLR    = 3'd4;
    localparam logic [2:0] OP_POP    = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_BIT_PERIOD   = 1'b0;
    localparam logic CFG_INSTANT_MODE = 1'b1;

    localparam int CFG_DATA_W  = 16;
    localparam int FRAME_W     = 19;
    localparam int PERIOD_W    = 15;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } fifo_cmd_t;

endpackage

// ===== hw/rtl/udbtr_if.sv =====
// Handshake channels of the UART core: the operation channel and the
// result channel. Depends on nothing.
`timescale 1ns / 1ps

interface udbtr_op_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] data_word;
    logic [15:0] tick_cycles;
    logic [7:0]  rx_byte;

    modport source (output valid, operation, data_word, tick_cycles, rx_byte, input ready);
    modport sink   (input valid, operation, data_word, tick_cycles, rx_byte, output ready);
endinterface

interface udbtr_res_if #(
    parameter int PENDING_W = 5
);
    logic                 valid;
    logic                 ready;
    logic [15:0]          status_word;
    logic                 tbe_irq;
    logic                 rbf_irq;
    logic [7:0]           tx_byte;
    logic                 tx_byte_valid;
    logic [PENDING_W-1:0] tx_pending;
    logic                 tx_lost;

    modport source (output valid, status_word, tbe_irq, rbf_irq, tx_byte, tx_byte_valid,
                    tx_pending, tx_lost, input ready);
    modport sink   (input valid, status_word, tbe_irq, rbf_irq, tx_byte, tx_byte_valid,
                    tx_pending, tx_lost, output ready);
endinterface

// ===== hw/rtl/uart_double_buffered_tx_rx_core.sv =====
// Double-buffered UART core: transmit holding and shift registers, receive
// buffer, transmit output FIFO. Depends on udbtr_pkg, udbtr_if, udbtr_fifo.
// The operation is held in the input register once accepted, and its result
// is loaded into the result register when the operation fires.
// Throughput: one operation per cycle while results are taken; the input
// register and the result register let a new transaction enter while a result waits.
// The res interface is to be built with PENDING_W = $clog2(FIFO_DEPTH + 1).
// Reset clears the control, configuration and buffer state.
`timescale 1ns / 1ps

module uart_double_buffered_tx_rx_core
    import udbtr_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    udbtr_op_if.sink              op,
    udbtr_res_if.source           res
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration.
    logic [15:0] bit_period_reg;
    logic        instant_mode_reg;

    // Input register.
    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [7:0]  in_data_reg;
    logic [15:0] in_cycles_reg;
    logic [7:0]  in_rx_reg;

    // Transmit and receive state.
    logic [7:0]         hold_byte_reg, hold_byte_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [7:0]         shift_byte_reg, shift_byte_next;
    logic               shift_busy_reg, shift_busy_next;
    logic [FRAME_W-1:0] frame_left_reg, frame_left_next;
    logic [8:0]         rx_word_reg, rx_word_next;
    logic               rx_full_reg, rx_full_next;
    logic               rx_overrun_reg, rx_overrun_next;

    // Current FIFO occupancy, kept beside the FIFO for the empty check on pop.
    logic [CNT_W-1:0] count_shadow_reg;

    // Result register.
    logic             out_valid_reg;
    logic [15:0]      status_reg;
    logic             tbe_reg;
    logic             rbf_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_byte_valid_reg;
    logic [CNT_W-1:0] pending_reg;
    logic             lost_reg;

    logic               fire;
    logic               in_take;
    logic [FRAME_W-1:0] bit_cycles;
    logic [FRAME_W-1:0] frame_len;
    logic               tbe;
    logic               rbf;
    logic               start;
    fifo_cmd_t          step_cmd;
    fifo_cmd_t          fifo_cmd;
    logic [7:0]         head_data;
    logic [CNT_W-1:0]   count_next;
    logic               lost_next;
    logic [15:0]        status_next;

    assign fire    = in_valid_reg && (!out_valid_reg || res.ready);
    assign in_take = op.valid && op.ready;
    assign op.ready = !in_valid_reg || fire;

    assign bit_cycles = FRAME_W'(bit_period_reg[PERIOD_W-1:0]) + 1'b1;
    assign frame_len  = (bit_cycles << 3) + (bit_cycles << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= '0;
            instant_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BIT_PERIOD:   bit_period_reg   <= cfg_wdata;
                CFG_INSTANT_MODE: instant_mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        hold_byte_next  = hold_byte_reg;
        hold_valid_next = hold_valid_reg;
        shift_byte_next = shift_byte_reg;
        shift_busy_next = shift_busy_reg;
        frame_left_next = frame_left_reg;
        rx_word_next    = rx_word_reg;
        rx_full_next    = rx_full_reg;
        rx_overrun_next = rx_overrun_reg;
        step_cmd        = '0;
        tbe             = 1'b0;
        rbf             = 1'b0;
        start           = 1'b0;

        case (in_op_reg)
            OP_WRITE:
            begin
                if (instant_mode_reg)
                begin
                    step_cmd.push      = 1'b1;
                    step_cmd.push_data = in_data_reg;
                    tbe                = 1'b1;
                end
                else
                begin
                    hold_byte_next  = in_data_reg;
                    hold_valid_next = 1'b1;
                    start           = !shift_busy_reg;
                end
            end
            OP_TICK:
            begin
                if (!shift_busy_reg)
                begin
                    start = hold_valid_reg;
                end
                else if (FRAME_W'(in_cycles_reg) < frame_left_reg)
                begin
                    frame_left_next = frame_left_reg - FRAME_W'(in_cycles_reg);
                end
                else
                begin
                    // Frame done: leftover cycles are dropped, a held word restarts.
                    shift_busy_next = 1'b0;
                    frame_left_next = '0;
                    shift_byte_next = '0;
                    if (!instant_mode_reg)
                    begin
                        step_cmd.push      = 1'b1;
                        step_cmd.push_data = shift_byte_reg;
                    end
                    start = hold_valid_reg;
                end
            end
            OP_RX:
            begin
                rx_overrun_next = rx_overrun_reg | rx_full_reg;
                rx_word_next    = {1'b1, in_rx_reg};
                rx_full_next    = 1'b1;
                rbf             = 1'b1;
            end
            OP_CLR:
            begin
                rx_full_next    = 1'b0;
                rx_word_next    = '0;
                rx_overrun_next = 1'b0;
            end
            OP_POP:
            begin
                step_cmd.pop = (count_shadow_reg != '0);
            end
            default:
            begin
            end
        endcase

        // Move the held word into the shifter; in instant mode it is queued now.
        if (start)
        begin
            shift_byte_next = hold_byte_next;
            shift_busy_next = 1'b1;
            frame_left_next = frame_len;
            hold_valid_next = 1'b0;
            tbe             = 1'b1;
            if (instant_mode_reg)
            begin
                step_cmd.push      = 1'b1;
                step_cmd.push_data = hold_byte_next;
            end
        end

        status_next = {rx_overrun_next, rx_full_next, !hold_valid_next, !shift_busy_next,
                       1'b1, 2'b00, rx_word_next};
    end

    assign fifo_cmd.push      = fire && step_cmd.push;
    assign fifo_cmd.pop       = fire && step_cmd.pop;
    assign fifo_cmd.push_data = step_cmd.push_data;

    udbtr_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (fifo_cmd),
        .head_data  (head_data),
        .count_next (count_next),
        .lost_next  (lost_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            hold_valid_reg   <= 1'b0;
            shift_busy_reg   <= 1'b0;
            frame_left_reg   <= '0;
            rx_word_reg      <= '0;
            rx_full_reg      <= 1'b0;
            rx_overrun_reg   <= 1'b0;
            hold_byte_reg    <= '0;
            shift_byte_reg   <= '0;
            count_shadow_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            count_shadow_reg <= count_next;

            if (fire)
            begin
                hold_byte_reg  <= hold_byte_next;
                hold_valid_reg <= hold_valid_next;
                shift_byte_reg <= shift_byte_next;
                shift_busy_reg <= shift_busy_next;
                frame_left_reg <= frame_left_next;
                rx_word_reg    <= rx_word_next;
                rx_full_reg    <= rx_full_next;
                rx_overrun_reg <= rx_overrun_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg     <= op.operation;
            in_data_reg   <= op.data_word[7:0];
            in_cycles_reg <= op.tick_cycles;
            in_rx_reg     <= op.rx_byte;
        end
        if (fire)
        begin
            status_reg        <= status_next;
            tbe_reg           <= tbe;
            rbf_reg           <= rbf;
            tx_byte_reg       <= step_cmd.pop ? head_data : 8'd0;
            tx_byte_valid_reg <= step_cmd.pop;
            pending_reg       <= count_next;
            lost_reg          <= lost_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status_word   = status_reg;
    assign res.tbe_irq       = tbe_reg;
    assign res.rbf_irq       = rbf_reg;
    assign res.tx_byte       = tx_byte_reg;
    assign res.tx_byte_valid = tx_byte_valid_reg;
    assign res.tx_pending    = pending_reg;
    assign res.tx_lost       = lost_reg;

endmodule

// ===== hw/rtl/udbtr_fifo.sv =====
// Transmit output FIFO with registered read at the head and a sticky
// overflow flag. Depends on udbtr_pkg.
`timescale 1ns / 1ps

module udbtr_fifo
    import udbtr_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fifo_cmd_t        cmd,
    output logic [7:0]       head_data,
    output logic [CNT_W-1:0] count_next,
    output logic             lost_next
);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       head_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg;
    logic             lost_reg;
    logic             full;
    logic             do_push;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        do_push   = cmd.push && !full;
        lost_next = lost_reg | (cmd.push && full);

        tail_next = tail_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end

        head_next = head_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end

        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            lost_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            lost_reg  <= lost_next;
        end
    end

    // The read port always follows the head, so the byte at the head is
    // registered and ready in the next cycle; a write to that same entry is forwarded.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= cmd.push_data;
        end
        if (do_push && (tail_reg == head_next))
        begin
            head_data_reg <= cmd.push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data = head_data_reg;

endmodule
